// File: sv/assert_macros.svh
// Assertion macros used by the checker of the best-fit allocator.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BFHA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define BFHA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: sv/bfha_pkg.sv
// Package of the best-fit heap allocator: sizes, codes and the block entry type.
// Used by the cell, the top level and the checker; depends on nothing.
`default_nettype none

package bfha_pkg;

  localparam int MAX_SEGMENTS    = 64;
  localparam int HEADER_BYTES    = 12;
  localparam int MIN_SPLIT_SLACK = 16;
  localparam int SEG_W           = $clog2(MAX_SEGMENTS + 1);

  localparam logic [23:0] HDR24      = 24'(HEADER_BYTES);
  localparam logic [23:0] RESET_HEAP = 24'd1048576;
  localparam logic [23:0] MIN_HEAP   = 24'd64;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ZERO    = 2'd1;
  localparam logic [1:0] STATUS_NOSPACE = 2'd2;
  localparam logic [1:0] STATUS_IGNORED = 2'd3;

  typedef struct packed {
    logic [23:0] off;
    logic [23:0] len;
    logic        busy;
  } seg_t;

  typedef enum logic [1:0] {
    CS_HOLD,
    CS_NEXT,
    CS_INJ
  } cell_sel_t;

endpackage

`default_nettype wire

// File: sv/best_fit_heap_allocator.sv
// Top level of the best-fit heap allocator: controller, head logic and the cell chain.
// Depends on bfha_pkg and bfha_cell.
//
//  Channel | Ports                                           | Handshake
//  input   | in_mode, in_request_size, in_address            | in_valid / in_ready
//  result  | out_status, out_payload_offset, out_used_bytes, | out_valid / out_ready
//          | out_free_bytes, out_free_block_count,           |
//          | out_peak_free                                   |
//  config  | cfg_wr_data (heap_bytes)                        | cfg_wr_en
//
// The table rotates through a chain of 64 cells past one head stage, one entry a cycle during a pass.
// An item takes one to seven passes over the table; one item at a time.
// Reset and a configuration write set the table to one free block at once, with no sweep.
// A waiting result holds the output register; the next item is still accepted and worked,
// but it waits in the done state until the output register is free.
`default_nettype none

module best_fit_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [23:0] in_request_size,
  input  wire logic [23:0] in_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [23:0]      out_payload_offset,
  output logic [23:0]      out_used_bytes,
  output logic [23:0]      out_free_bytes,
  output logic [6:0]       out_free_block_count,
  output logic [23:0]      out_peak_free,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data
);

  localparam int N  = bfha_pkg::MAX_SEGMENTS;
  localparam int SW = bfha_pkg::SEG_W;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_COAL   = 7'b0000100,
    ST_GRANT  = 7'b0001000,
    ST_FREE   = 7'b0010000,
    ST_STAT   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    HOP_NONE,
    HOP_ROT,
    HOP_MERGE,
    HOP_INS,
    HOP_INIT
  } hop_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] count_r, count_nxt, proc_r, proc_nxt, best_p_r, best_p_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [23:0] heap_r, heap_nxt, biu_r, biu_nxt;
  logic [24:0] size_r, size_nxt;
  logic [23:0] addr_r, addr_nxt, best_d_r, best_d_nxt, largest_r, largest_nxt;
  logic [23:0] payload_r, payload_nxt;
  logic [1:0]  status_r, status_nxt;
  logic found_r, found_nxt, retried_r, retried_nxt, to_search_r, to_search_nxt;
  logic zdone_r, zdone_nxt, zflag_r, zflag_nxt, hit_r, hit_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r;
  logic [23:0] out_payload_r, out_used_r, out_free_r, out_largest_r;
  logic [6:0]  out_cnt_r;
  logic        out_load;

  bfha_pkg::seg_t            cell_q   [N];
  bfha_pkg::seg_t            cell_nbr [N];
  bfha_pkg::seg_t            cell_inj [N];
  bfha_pkg::cell_sel_t       cell_sel [N];
  bfha_pkg::seg_t            head, nxt_e, head_inj, tail_inj;
  hop_t                      op;

  logic          pass_end, fits, can_merge, split, enter_stat;
  logic [SW-1:0] proc_p1, count_m1;
  logic [24:0]   diff;
  logic [25:0]   need;
  logic [24:0]   rel_sub, tag;
  logic [23:0]   init_heap;

  assign head     = cell_q[0];
  assign nxt_e    = cell_q[1];
  assign pass_end = (proc_r == count_r);
  assign proc_p1  = proc_r + SW'(1);
  assign count_m1 = count_r - SW'(1);
  assign fits     = !head.busy && ({1'b0, head.len} >= size_r);
  assign diff     = {1'b0, head.len} - size_r;
  assign can_merge = !head.busy && !nxt_e.busy && (proc_p1 < count_r);
  assign need     = {1'b0, size_r} + 26'(bfha_pkg::HEADER_BYTES + bfha_pkg::MIN_SPLIT_SLACK);
  assign split    = ({2'b0, head.len} >= need) && (count_r < SW'(N));
  assign rel_sub  = {1'b0, head.len} + {1'b0, bfha_pkg::HDR24};
  assign tag      = {1'b0, head.off} + {1'b0, bfha_pkg::HDR24};
  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    if (!rst_n) begin
      init_heap = bfha_pkg::RESET_HEAP;
    end else if (cfg_wr_data < bfha_pkg::MIN_HEAP) begin
      init_heap = bfha_pkg::MIN_HEAP;
    end else begin
      init_heap = cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    proc_nxt      = proc_r;
    best_p_nxt    = best_p_r;
    best_d_nxt    = best_d_r;
    cnt_nxt       = cnt_r;
    largest_nxt   = largest_r;
    heap_nxt      = heap_r;
    biu_nxt       = biu_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    payload_nxt   = payload_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    retried_nxt   = retried_r;
    to_search_nxt = to_search_r;
    zdone_nxt     = zdone_r;
    zflag_nxt     = zflag_r;
    hit_nxt       = hit_r;
    op            = HOP_NONE;
    head_inj      = head;
    tail_inj      = head;
    enter_stat    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          proc_nxt      = '0;
          status_nxt    = bfha_pkg::STATUS_OK;
          payload_nxt   = '0;
          found_nxt     = 1'b0;
          retried_nxt   = 1'b0;
          to_search_nxt = 1'b0;
          zdone_nxt     = 1'b0;
          hit_nxt       = 1'b0;
          size_nxt      = ({1'b0, in_request_size} + 25'd3) & ~25'd3;
          addr_nxt      = in_address;
          if (in_mode == bfha_pkg::MODE_ALLOC) begin
            if (in_request_size == '0) begin
              status_nxt = bfha_pkg::STATUS_ZERO;
              enter_stat = 1'b1;
            end else begin
              state_nxt = ST_SEARCH;
            end
          end else if (in_mode == bfha_pkg::MODE_FREE) begin
            if (in_address < heap_r) begin
              state_nxt = ST_FREE;
            end else begin
              status_nxt = bfha_pkg::STATUS_IGNORED;
              enter_stat = 1'b1;
            end
          end else begin
            state_nxt = ST_COAL;
          end
        end
      end
      ST_SEARCH: begin
        if (pass_end) begin
          proc_nxt = '0;
          if (found_r) begin
            state_nxt = ST_GRANT;
          end else if (!retried_r) begin
            retried_nxt   = 1'b1;
            to_search_nxt = 1'b1;
            state_nxt     = ST_COAL;
          end else begin
            status_nxt = bfha_pkg::STATUS_NOSPACE;
            enter_stat = 1'b1;
          end
        end else begin
          op       = HOP_ROT;
          proc_nxt = proc_p1;
          if (fits && (!found_r || diff[23:0] < best_d_r)) begin
            found_nxt  = 1'b1;
            best_p_nxt = proc_r;
            best_d_nxt = diff[23:0];
          end
        end
      end
      ST_COAL: begin
        if (pass_end) begin
          proc_nxt = '0;
          if (to_search_r) begin
            to_search_nxt = 1'b0;
            state_nxt     = ST_SEARCH;
          end else begin
            enter_stat = 1'b1;
          end
        end else if (can_merge) begin
          op           = HOP_MERGE;
          head_inj.len = head.len + bfha_pkg::HDR24 + nxt_e.len;
          count_nxt    = count_m1;
        end else begin
          op       = HOP_ROT;
          proc_nxt = proc_p1;
        end
      end
      ST_GRANT: begin
        if (pass_end) begin
          proc_nxt   = '0;
          enter_stat = 1'b1;
        end else begin
          proc_nxt = proc_p1;
          if (proc_r == best_p_r) begin
            payload_nxt = tag[23:0];
            if (split) begin
              op            = HOP_INS;
              tail_inj.len  = size_r[23:0];
              tail_inj.busy = 1'b1;
              head_inj.off  = head.off + bfha_pkg::HDR24 + size_r[23:0];
              head_inj.len  = head.len - size_r[23:0] - bfha_pkg::HDR24;
              head_inj.busy = 1'b0;
              count_nxt     = count_r + SW'(1);
              biu_nxt       = biu_r + size_r[23:0] + bfha_pkg::HDR24;
            end else begin
              op            = HOP_ROT;
              tail_inj.busy = 1'b1;
              biu_nxt       = biu_r + head.len + bfha_pkg::HDR24;
            end
          end else begin
            op = HOP_ROT;
          end
        end
      end
      ST_FREE: begin
        if (pass_end) begin
          proc_nxt = '0;
          if (hit_r) begin
            state_nxt = ST_COAL;
          end else begin
            status_nxt = bfha_pkg::STATUS_IGNORED;
            enter_stat = 1'b1;
          end
        end else begin
          op       = HOP_ROT;
          proc_nxt = proc_p1;
          if (!hit_r && head.busy && (tag == {1'b0, addr_r})) begin
            hit_nxt       = 1'b1;
            tail_inj.busy = 1'b0;
            biu_nxt       = (rel_sub <= {1'b0, biu_r}) ? (biu_r - rel_sub[23:0]) : '0;
          end
        end
      end
      ST_STAT: begin
        if (pass_end) begin
          proc_nxt = '0;
          if (zflag_r && !zdone_r) begin
            zdone_nxt = 1'b1;
            state_nxt = ST_COAL;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          op       = HOP_ROT;
          proc_nxt = proc_p1;
          if (!head.busy) begin
            cnt_nxt = cnt_r + SW'(1);
            if (head.len > largest_r) begin
              largest_nxt = head.len;
            end
            if (head.len == '0 && proc_p1 < count_r) begin
              zflag_nxt = 1'b1;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (enter_stat) begin
      state_nxt   = ST_STAT;
      cnt_nxt     = '0;
      largest_nxt = '0;
      zflag_nxt   = 1'b0;
    end

    if (!rst_n || cfg_wr_en) begin
      op            = HOP_INIT;
      head_inj.off  = '0;
      head_inj.len  = init_heap - bfha_pkg::HDR24;
      head_inj.busy = 1'b0;
      heap_nxt      = init_heap;
      count_nxt     = SW'(1);
      biu_nxt       = '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_chain
    if (k == N - 1) begin : g_end
      assign cell_nbr[k] = '0;
    end else begin : g_mid
      assign cell_nbr[k] = cell_q[k+1];
    end

    always_comb begin
      if (k == 0 && op != HOP_ROT) begin
        cell_inj[k] = head_inj;
      end else begin
        cell_inj[k] = tail_inj;
      end
      unique case (op)
        HOP_INIT:  cell_sel[k] = (k == 0) ? bfha_pkg::CS_INJ : bfha_pkg::CS_HOLD;
        HOP_ROT:   cell_sel[k] = (SW'(k) == count_m1) ? bfha_pkg::CS_INJ : bfha_pkg::CS_NEXT;
        HOP_MERGE: cell_sel[k] = (k == 0) ? bfha_pkg::CS_INJ : bfha_pkg::CS_NEXT;
        HOP_INS:   cell_sel[k] = (k == 0 || SW'(k) == count_r) ? bfha_pkg::CS_INJ
                                                               : bfha_pkg::CS_HOLD;
        default:   cell_sel[k] = bfha_pkg::CS_HOLD;
      endcase
    end

    bfha_cell u_cell (
      .clk (clk),
      .sel (cell_sel[k]),
      .nbr (cell_nbr[k]),
      .inj (cell_inj[k]),
      .q   (cell_q[k])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= SW'(1);
      proc_r      <= '0;
      heap_r      <= bfha_pkg::RESET_HEAP;
      biu_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      retried_r   <= 1'b0;
      to_search_r <= 1'b0;
      zdone_r     <= 1'b0;
      zflag_r     <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      proc_r      <= proc_nxt;
      heap_r      <= heap_nxt;
      biu_r       <= biu_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      retried_r   <= retried_nxt;
      to_search_r <= to_search_nxt;
      zdone_r     <= zdone_nxt;
      zflag_r     <= zflag_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_p_r  <= best_p_nxt;
    best_d_r  <= best_d_nxt;
    cnt_r     <= cnt_nxt;
    largest_r <= largest_nxt;
    size_r    <= size_nxt;
    addr_r    <= addr_nxt;
    payload_r <= payload_nxt;
    status_r  <= status_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_payload_r <= payload_r;
      out_used_r    <= biu_r;
      out_free_r    <= (heap_r >= biu_r) ? (heap_r - biu_r) : '0;
      out_cnt_r     <= 7'(cnt_r);
      out_largest_r <= largest_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_payload_offset   = out_payload_r;
  assign out_used_bytes       = out_used_r;
  assign out_free_bytes       = out_free_r;
  assign out_free_block_count = out_cnt_r;
  assign out_peak_free        = out_largest_r;

endmodule

`default_nettype wire

// File: sv/bfha_cell.sv
// One cell of the block table chain: holds one block entry.
// Loads from its right-hand neighbour, from the injection bus, or holds; uses bfha_pkg.
`default_nettype none

module bfha_cell (
  input  wire logic                 clk,
  input  wire bfha_pkg::cell_sel_t  sel,
  input  wire bfha_pkg::seg_t       nbr,
  input  wire bfha_pkg::seg_t       inj,
  output bfha_pkg::seg_t            q
);

  bfha_pkg::seg_t q_r;
  bfha_pkg::seg_t q_nxt;

  always_comb begin
    unique case (sel)
      bfha_pkg::CS_NEXT: q_nxt = nbr;
      bfha_pkg::CS_INJ:  q_nxt = inj;
      default:           q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: sv/bfha_checker.sv
// Port-level checker for the best-fit heap allocator, bound to the top level.
// Depends on bfha_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bfha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [23:0] out_payload_offset,
  input wire logic [6:0]  out_free_block_count,
  input wire logic [23:0] out_peak_free
);

  `BFHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload_offset), "result item changed while stalled")
  `BFHA_ASSERT(a_fail_no_offset, !out_valid || out_status == bfha_pkg::STATUS_OK || out_payload_offset == '0, "failed item carries an offset")
  `BFHA_ASSERT(a_count_range, !out_valid || out_free_block_count <= 7'(bfha_pkg::MAX_SEGMENTS), "free block count out of range")
  `BFHA_ASSERT(a_largest_needs_block, !out_valid || out_peak_free == '0 || out_free_block_count != '0, "largest free size without a free block")
  `BFHA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second item accepted straight after the first")

endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (.*);

`default_nettype wire

// File: dv/best_fit_heap_allocator_tb.sv
// Self-checking testbench for best_fit_heap_allocator: directed and random items,
// compared field by field with a behavioural allocator model held in this file.
// Depends on bfha_pkg and the allocator RTL.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_heap_allocator_tb;

  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [1:0]  status;
    logic [23:0] payload;
    logic [23:0] used;
    logic [23:0] spare;
    logic [6:0]  nfree;
    logic [23:0] biggest;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [23:0] in_request_size = '0;
  logic [23:0] in_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [23:0] out_payload_offset;
  logic [23:0] out_used_bytes;
  logic [23:0] out_free_bytes;
  logic [6:0] out_free_block_count;
  logic [23:0] out_peak_free;
  logic cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;

  heap_result_t expected_q[$];
  int unsigned live_q[$];
  int errors = 0;
  bit no_idle = 1'b0;
  logic hold_req = 1'b0;
  int hold_left = 0;

  // Model of the block table.
  int unsigned arena_bytes;
  int unsigned blk_off[bfha_pkg::MAX_SEGMENTS];
  int unsigned blk_len[bfha_pkg::MAX_SEGMENTS];
  bit blk_busy[bfha_pkg::MAX_SEGMENTS];
  int unsigned blk_count;
  int unsigned in_use;

  best_fit_heap_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_request_size(in_request_size), .in_address(in_address),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_payload_offset(out_payload_offset), .out_used_bytes(out_used_bytes),
    .out_free_bytes(out_free_bytes), .out_free_block_count(out_free_block_count),
    .out_peak_free(out_peak_free),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_table();
    for (int k = 0; k < bfha_pkg::MAX_SEGMENTS; k++) begin
      blk_off[k] = 0;
      blk_len[k] = 0;
      blk_busy[k] = 1'b0;
    end
    blk_len[0] = arena_bytes - bfha_pkg::HEADER_BYTES;
    blk_count = 1;
    in_use = 0;
    live_q.delete();
  endfunction

  function automatic void drop_block(int unsigned i);
    for (int unsigned k = i; k + 1 < blk_count; k++) begin
      blk_off[k] = blk_off[k + 1];
      blk_len[k] = blk_len[k + 1];
      blk_busy[k] = blk_busy[k + 1];
    end
    blk_count--;
  endfunction

  function automatic void merge_free();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_count) begin
      if (!blk_busy[i] && !blk_busy[i + 1]) begin
        blk_len[i] = blk_len[i] + bfha_pkg::HEADER_BYTES + blk_len[i + 1];
        drop_block(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic int find_best(int unsigned size);
    int best;
    int unsigned min_gap, d;
    best = -1;
    min_gap = 0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!blk_busy[i] && blk_len[i] >= size) begin
        d = blk_len[i] - size;
        if (best < 0 || d < min_gap) begin
          best = i;
          min_gap = d;
          if (d == 0) break;
        end
      end
    end
    return best;
  endfunction

  function automatic int unsigned take_block(int unsigned i, int unsigned size);
    if (longint'(blk_len[i]) >= longint'(size) + bfha_pkg::HEADER_BYTES +
        bfha_pkg::MIN_SPLIT_SLACK && blk_count < bfha_pkg::MAX_SEGMENTS) begin
      for (int unsigned k = blk_count; k > i + 1; k--) begin
        blk_off[k] = blk_off[k - 1];
        blk_len[k] = blk_len[k - 1];
        blk_busy[k] = blk_busy[k - 1];
      end
      blk_off[i + 1] = blk_off[i] + bfha_pkg::HEADER_BYTES + size;
      blk_len[i + 1] = blk_len[i] - size - bfha_pkg::HEADER_BYTES;
      blk_busy[i + 1] = 1'b0;
      blk_len[i] = size;
      blk_count++;
    end
    blk_busy[i] = 1'b1;
    in_use = (in_use + blk_len[i] + bfha_pkg::HEADER_BYTES) & 32'hFFFFFF;
    return blk_off[i] + bfha_pkg::HEADER_BYTES;
  endfunction

  function automatic heap_result_t predict_heap(logic [1:0] mode, logic [23:0] req,
                                                logic [23:0] addr);
    heap_result_t r;
    int unsigned size, sub, cnt, biggest, pay;
    int b, hit;
    r.status = bfha_pkg::STATUS_OK;
    pay = 0;
    if (mode == bfha_pkg::MODE_ALLOC) begin
      if (req == 0) begin
        r.status = bfha_pkg::STATUS_ZERO;
      end else begin
        size = (int'(req) + 3) & ~32'd3;
        b = find_best(size);
        if (b < 0) begin
          merge_free();
          b = find_best(size);
        end
        if (b < 0) r.status = bfha_pkg::STATUS_NOSPACE;
        else begin
          pay = take_block(b, size);
          live_q.push_back(pay);
        end
      end
    end else if (mode == bfha_pkg::MODE_FREE) begin
      hit = -1;
      if (addr < arena_bytes) begin
        for (int unsigned i = 0; i < blk_count; i++) begin
          if (blk_busy[i] && blk_off[i] + bfha_pkg::HEADER_BYTES == addr) begin
            hit = i;
            break;
          end
        end
      end
      if (hit < 0) begin
        r.status = bfha_pkg::STATUS_IGNORED;
      end else begin
        sub = blk_len[hit] + bfha_pkg::HEADER_BYTES;
        in_use = (sub <= in_use) ? in_use - sub : 0;
        blk_busy[hit] = 1'b0;
        merge_free();
        foreach (live_q[j]) if (live_q[j] == addr) begin
          live_q.delete(j);
          break;
        end
      end
    end else begin
      merge_free();
    end
    for (int unsigned i = 0; i + 1 < blk_count; i++) begin
      if (!blk_busy[i] && blk_len[i] == 0) begin
        merge_free();
        break;
      end
    end
    cnt = 0;
    biggest = 0;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!blk_busy[i]) begin
        cnt++;
        if (blk_len[i] > biggest) biggest = blk_len[i];
      end
    end
    r.payload = pay[23:0];
    r.used = in_use[23:0];
    r.spare = (arena_bytes >= in_use) ? 24'(arena_bytes - in_use) : 24'd0;
    r.nfree = cnt[6:0];
    r.biggest = biggest[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, status", 24'(out_status), 24'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status)
            report_mismatch("status", 24'(out_status), 24'(e.status));
          if (out_payload_offset !== e.payload)
            report_mismatch("payload_offset", out_payload_offset, e.payload);
          if (out_used_bytes !== e.used) report_mismatch("used_bytes", out_used_bytes, e.used);
          if (out_free_bytes !== e.spare) report_mismatch("free_bytes", out_free_bytes, e.spare);
          if (out_free_block_count !== e.nfree)
            report_mismatch("free_block_count", 24'(out_free_block_count), 24'(e.nfree));
          if (out_peak_free !== e.biggest)
            report_mismatch("peak_free", out_peak_free, e.biggest);
        end
      end
      out_ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 29);
    end
  end

  task automatic send_item(logic [1:0] mode, logic [23:0] req, logic [23:0] addr);
    int gap;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_request_size <= req;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_heap(mode, req, addr));
    gap = (!no_idle && $urandom_range(99) < 29) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_arena(logic [23:0] value);
    in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    arena_bytes = 32'((value < bfha_pkg::MIN_HEAP) ? bfha_pkg::MIN_HEAP : value);
    clear_table();
  endtask

  task automatic test_reset_and_edges();
    send_item(MODE_QUERY, 24'h0, 24'h0);
    send_item(MODE_SPARE, 24'hFFFFFF, 24'hFFFFFF);
    send_item(bfha_pkg::MODE_ALLOC, 24'd0, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'hFFFFFF, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd1, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd4, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd5, 24'h0);
    send_item(bfha_pkg::MODE_FREE, 24'h0, 24'hFFFFFF);
    send_item(bfha_pkg::MODE_FREE, 24'h0, 24'd0);
    send_item(bfha_pkg::MODE_FREE, 24'h0, 24'd13);
    send_item(bfha_pkg::MODE_FREE, 24'hFFFFFF, 24'd28);
    send_item(bfha_pkg::MODE_FREE, 24'h0, 24'd12);
    send_item(bfha_pkg::MODE_FREE, 24'h0, 24'd12);
  endtask

  task automatic test_small_arena();
    set_arena(24'd0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd52, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd1, 24'h0);
    send_item(bfha_pkg::MODE_FREE, 24'h0, 24'd12);
    set_arena(24'd63);
    send_item(bfha_pkg::MODE_ALLOC, 24'd20, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd8, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd4, 24'h0);
    send_item(MODE_QUERY, 24'h0, 24'h0);
  endtask

  task automatic test_max_arena();
    set_arena(24'hFFFFFF);
    send_item(bfha_pkg::MODE_ALLOC, 24'hFFFFF3, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'hFFFFF0, 24'h0);
    send_item(bfha_pkg::MODE_ALLOC, 24'd4, 24'h0);
    send_item(bfha_pkg::MODE_FREE, 24'h0, 24'd12);
    send_item(bfha_pkg::MODE_ALLOC, 24'h800000, 24'h0);
  endtask

  task automatic test_table_full();
    set_arena(24'd4096);
    for (int k = 0; k < 70; k++) send_item(bfha_pkg::MODE_ALLOC, 24'd4, 24'h0);
    for (int k = 0; k < 20; k++)
      send_item(bfha_pkg::MODE_FREE, 24'h0, 24'(live_q[$urandom_range(0, 30)]));
    send_item(bfha_pkg::MODE_ALLOC, 24'd40, 24'h0);
    send_item(MODE_QUERY, 24'h0, 24'h0);
  endtask

  task automatic test_random(logic [23:0] arena, int count);
    int r;
    logic [23:0] req, addr;
    set_arena(arena);
    for (int k = 0; k < count; k++) begin
      no_idle = (k >= count / 2 && k < count / 2 + 60);
      r = $urandom_range(99);
      req = 24'($urandom);
      addr = 24'($urandom);
      if (r < 50) begin
        r = $urandom_range(99);
        if (r < 70) req = 24'($urandom_range(1, 96));
        else if (r < 90) req = 24'($urandom_range(1, arena_bytes / 8 + 1));
        send_item(bfha_pkg::MODE_ALLOC, req, addr);
      end else if (r < 85) begin
        if (live_q.size() != 0 && $urandom_range(99) < 85)
          addr = 24'(live_q[$urandom_range(0, live_q.size() - 1)]);
        send_item(bfha_pkg::MODE_FREE, req, addr);
      end else begin
        send_item(($urandom_range(1) != 0) ? MODE_QUERY : MODE_SPARE, req, addr);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int k = 0; k < 8; k++)
      send_item(bfha_pkg::MODE_ALLOC, 24'($urandom_range(1, 64)), 24'($urandom));
  endtask

  initial begin
    arena_bytes = 32'(bfha_pkg::RESET_HEAP);
    clear_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_and_edges();
    test_small_arena();
    test_max_arena();
    test_table_full();
    test_random(24'd1024, 300);
    test_random(24'd4096, 350);
    test_random(24'd300, 250);
    test_backpressure();
    test_random(24'hFFFFFF, 250);
    test_random(24'($urandom_range(64, 20000)), 300);
    test_random(24'd64, 100);
    in_valid <= 1'b0;
    drain();
    repeat (500) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
